// File: rtl/core/bpa_pkg.sv
// shared types and constants of the buddy page allocator
`timescale 1ns / 1ps

package bpa_pkg;

    // field widths
    localparam int OPCODE_W = 2;
    localparam int PAGE_W   = 16;
    localparam int COUNT_W  = 17;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // default sizing
    localparam int MAX_ORDER_DEF  = 10;
    localparam int PAGE_COUNT_DEF = 65536;

    // used map is kept in words of this many pages
    localparam int WORD_BITS = 32;

    // register reset values
    localparam logic [COUNT_W-1:0] TOTAL_PAGES_RST     = COUNT_W'(65536);
    localparam logic [COUNT_W-1:0] PROTECTED_PAGES_RST = COUNT_W'(256);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_PAGES     = 1'b0,
        CFG_PROTECTED_PAGES = 1'b1
    } t_cfg_index;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REGION = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_MEMORY = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    // what the bitmap walker does over a page range
    typedef enum logic [1:0] {
        WM_SET,
        WM_CLR,
        WM_CHK
    } t_walk_mode;

endpackage

// File: rtl/core/bpa_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/buddy_page_allocator_top.sv
// buddy page allocator: used bitmap and per-order free lists held in rams
// alloc, free and region requests run a sequencer that reads and rewrites bitmap words
// of 32 pages and scans or moves free list entries one at a time
// throughput: one request at a time, next request taken once the result is queued
// reset: synchronous; a clearing pass then marks every page used, one bitmap word a
// cycle, and no request is taken until it ends
`timescale 1ns / 1ps

module buddy_page_allocator_top #(
    parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF,
    parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bpa_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_first_page,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_count,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpa_pkg::PAGE_W-1:0]    o_block_page,
    output logic [bpa_pkg::STATUS_W-1:0]  o_status,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_cfg_data
);

    import bpa_pkg::*;

    localparam int NUM_ORDERS = MAX_ORDER + 1;
    localparam int OIW    = $clog2(NUM_ORDERS);
    localparam int PW     = ($clog2(PAGE_COUNT) + 3 > 20) ? $clog2(PAGE_COUNT) + 3 : 20;
    localparam int WSH    = $clog2(WORD_BITS);
    localparam int WIW    = PW - WSH;
    localparam int NW     = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW    = $clog2(NW);
    localparam int LDEPTH = 2 * PAGE_COUNT;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int LENW   = $clog2(PAGE_COUNT) + 1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_A_POP,
        S_A_SPLIT,
        S_A_PUSH,
        S_FREE,
        S_F_LOOP,
        S_F_CHK,
        S_R_RD,
        S_R_CMP,
        S_M_RD,
        S_M_WR,
        S_F_PUSH,
        S_REGION,
        S_G_WALK,
        S_G_USED,
        S_G_TRY,
        S_G_TRYC,
        S_W_START,
        S_W_RD,
        S_W_MOD,
        S_DONE
    } t_state;

    // round a page count up to an order, saturating at the top order
    function automatic logic [OIW-1:0] order_of(input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] cm1;
        int                 bl;
        cm1 = cnt - COUNT_W'(1);
        bl  = 0;
        for (int b = 0; b < COUNT_W; b++) begin
            if (cm1[b]) begin
                bl = b + 1;
            end
        end
        if (bl > MAX_ORDER) begin
            bl = MAX_ORDER;
        end
        return OIW'(bl);
    endfunction

    // first list slot of an order
    function automatic logic [LAW-1:0] base_of(input logic [OIW-1:0] o);
        int unsigned acc;
        acc = 0;
        for (int j = 0; j < NUM_ORDERS; j++) begin
            if (j < int'(o)) begin
                acc = acc + (PAGE_COUNT >> j);
            end
        end
        return LAW'(acc);
    endfunction

    // number of slots of an order
    function automatic logic [LENW-1:0] cap_of(input logic [OIW-1:0] o);
        return LENW'(PAGE_COUNT >> o);
    endfunction

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    t_walk_mode r_mode, n_mode;
    logic [PW-1:0]   r_lo, n_lo;
    logic [PW-1:0]   r_hi, n_hi;
    logic [WIW-1:0]  r_w, n_w;
    logic [WIW-1:0]  r_wl, n_wl;
    logic            r_free, n_free;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PW-1:0]   r_page, n_page;
    logic [PW-1:0]   r_end, n_end;
    logic [PW-1:0]   r_q, n_q;
    logic [PW-1:0]   r_blk, n_blk;
    logic [OIW-1:0]  r_o, n_o;
    logic [OIW-1:0]  r_want, n_want;
    logic [LENW-1:0] r_i, n_i;
    logic [LENW-1:0] r_len [NUM_ORDERS];
    logic [LENW-1:0] n_len [NUM_ORDERS];
    logic [COUNT_W-1:0] r_total, n_total;
    logic [COUNT_W-1:0] r_prot, n_prot;
    logic [PAGE_W-1:0]   r_res_page, n_res_page;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    // bitmap ram
    logic                 u_we;
    logic [WAW-1:0]       u_waddr;
    logic [WORD_BITS-1:0] u_wdata;
    logic [WAW-1:0]       u_raddr;
    logic [WORD_BITS-1:0] u_rdata;

    // free list ram
    logic           l_we;
    logic [LAW-1:0] l_waddr;
    logic [PW-1:0]  l_wdata;
    logic [LAW-1:0] l_raddr;
    logic [PW-1:0]  l_rdata;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    ) u_used_map (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    bpa_ram #(
        .WIDTH (PW),
        .DEPTH (LDEPTH)
    ) u_free_lists (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_block_page = r_out_page;
    assign o_status     = r_out_status;

    // sequencer
    always_comb begin
        logic [PW-1:0]        bp;
        logic [PW-1:0]        hi_c;
        logic [PW-1:0]        hm1;
        logic [PW-1:0]        lo_r;
        logic [PW-1:0]        hi_r;
        logic [WSH-1:0]       lob;
        logic [WSH-1:0]       hib;
        logic [WORD_BITS-1:0] mask;
        logic                 found;
        logic [OIW-1:0]       fo;
        logic [OIW-1:0]       want;

        n_state      = r_state;
        n_ret        = r_ret;
        n_mode       = r_mode;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_w          = r_w;
        n_wl         = r_wl;
        n_free       = r_free;
        n_count      = r_count;
        n_page       = r_page;
        n_end        = r_end;
        n_q          = r_q;
        n_blk        = r_blk;
        n_o          = r_o;
        n_want       = r_want;
        n_i          = r_i;
        n_len        = r_len;
        n_total      = r_total;
        n_prot       = r_prot;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_page   = r_out_page;
        n_out_status = r_out_status;

        u_we    = 1'b0;
        u_waddr = r_w[WAW-1:0];
        u_wdata = '1;
        u_raddr = r_w[WAW-1:0];
        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = r_page;
        l_raddr = '0;

        bp    = PW'(1) << r_o;
        hi_c  = r_hi;
        hm1   = r_hi - PW'(1);
        lo_r  = '0;
        hi_r  = '0;
        lob   = '0;
        hib   = '0;
        mask  = '0;
        found = 1'b0;
        fo    = '0;
        want  = order_of(r_count);

        // result beat taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration writes
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TOTAL_PAGES:     n_total = i_cfg_data;
                CFG_PROTECTED_PAGES: n_prot  = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            // set every bitmap word to all used
            S_INIT: begin
                u_we    = 1'b1;
                u_wdata = '1;
                if (r_w == WIW'(NW - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + WIW'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_count      = i_page_count;
                    n_page       = PW'(i_first_page);
                    n_res_page   = '0;
                    n_res_status = ST_OK;
                    unique case (t_opcode'(i_opcode))
                        OP_ALLOC:  n_state = S_ALLOC;
                        OP_FREE:   n_state = S_FREE;
                        OP_REGION: n_state = S_REGION;
                        OP_RSVD: begin
                            n_res_status = ST_BAD_COUNT;
                            n_state      = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            // pick the smallest non-empty order at or above the wanted one and pop it
            S_ALLOC: begin
                for (int k = MAX_ORDER; k >= 0; k--) begin
                    if (k >= int'(want) && r_len[k] != '0) begin
                        found = 1'b1;
                        fo    = OIW'(k);
                    end
                end
                if (r_count == '0 ||
                    PW'(r_count) > (PW'(1) << MAX_ORDER)) begin
                    n_res_status = ST_BAD_COUNT;
                    n_state      = S_DONE;
                end else if (!found) begin
                    n_res_status = ST_NO_MEMORY;
                    n_state      = S_DONE;
                end else begin
                    n_o       = fo;
                    n_want    = want;
                    n_len[fo] = r_len[fo] - LENW'(1);
                    l_raddr   = base_of(fo) + LAW'(r_len[fo] - LENW'(1));
                    n_state   = S_A_POP;
                end
            end

            S_A_POP: begin
                n_blk   = l_rdata;
                n_lo    = l_rdata;
                n_hi    = l_rdata + bp;
                n_mode  = WM_SET;
                n_ret   = S_A_SPLIT;
                n_state = S_W_START;
            end

            // hand back the upper halves, high order first
            S_A_SPLIT: begin
                if (r_o > r_want) begin
                    n_o     = r_o - OIW'(1);
                    n_q     = r_blk + (bp >> 1);
                    n_lo    = r_blk + (bp >> 1);
                    n_hi    = r_blk + bp;
                    n_mode  = WM_CLR;
                    n_ret   = S_A_PUSH;
                    n_state = S_W_START;
                end else begin
                    n_res_page = r_blk[PAGE_W-1:0];
                    n_state    = S_DONE;
                end
            end

            S_A_PUSH: begin
                if (r_len[r_o] < cap_of(r_o)) begin
                    l_we        = 1'b1;
                    l_waddr     = base_of(r_o) + LAW'(r_len[r_o]);
                    l_wdata     = r_q;
                    n_len[r_o]  = r_len[r_o] + LENW'(1);
                end
                n_state = S_A_SPLIT;
            end

            S_FREE: begin
                if (r_count == '0) begin
                    n_res_status = ST_BAD_COUNT;
                    n_state      = S_DONE;
                end else if (r_page >= PW'(r_total) || r_page < PW'(r_prot)) begin
                    n_res_status = ST_BAD_ADDR;
                    n_state      = S_DONE;
                end else begin
                    n_o     = want;
                    n_lo    = r_page;
                    n_hi    = r_page + (PW'(1) << want);
                    n_mode  = WM_CLR;
                    n_ret   = S_F_LOOP;
                    n_state = S_W_START;
                end
            end

            // test the buddy at the current order
            S_F_LOOP: begin
                if (r_o < OIW'(MAX_ORDER)) begin
                    n_q = r_page ^ bp;
                    if ((r_page ^ bp) >= PW'(r_total)) begin
                        n_state = S_F_PUSH;
                    end else begin
                        n_lo    = r_page ^ bp;
                        n_hi    = (r_page ^ bp) + bp;
                        n_mode  = WM_CHK;
                        n_ret   = S_F_CHK;
                        n_state = S_W_START;
                    end
                end else begin
                    n_state = S_F_PUSH;
                end
            end

            S_F_CHK: begin
                if (!r_free) begin
                    n_state = S_F_PUSH;
                end else begin
                    n_i     = r_len[r_o];
                    n_state = S_R_RD;
                end
            end

            // search the list from the top for the buddy
            S_R_RD: begin
                if (r_i == '0) begin
                    n_state = S_F_PUSH;
                end else begin
                    l_raddr = base_of(r_o) + LAW'(r_i - LENW'(1));
                    n_state = S_R_CMP;
                end
            end

            S_R_CMP: begin
                if (l_rdata == r_q) begin
                    n_state = S_M_RD;
                end else begin
                    n_i     = r_i - LENW'(1);
                    n_state = S_R_RD;
                end
            end

            // close the gap left by the removed entry
            S_M_RD: begin
                if (r_i < r_len[r_o]) begin
                    l_raddr = base_of(r_o) + LAW'(r_i);
                    n_state = S_M_WR;
                end else begin
                    n_len[r_o] = r_len[r_o] - LENW'(1);
                    if (r_q < r_page) begin
                        n_page = r_q;
                    end
                    n_o     = r_o + OIW'(1);
                    n_state = S_F_LOOP;
                end
            end

            S_M_WR: begin
                l_we    = 1'b1;
                l_waddr = base_of(r_o) + LAW'(r_i - LENW'(1));
                l_wdata = l_rdata;
                n_i     = r_i + LENW'(1);
                n_state = S_M_RD;
            end

            S_F_PUSH: begin
                if (r_len[r_o] < cap_of(r_o)) begin
                    l_we       = 1'b1;
                    l_waddr    = base_of(r_o) + LAW'(r_len[r_o]);
                    l_wdata    = r_page;
                    n_len[r_o] = r_len[r_o] + LENW'(1);
                end
                n_state = S_DONE;
            end

            // release the unprotected part of the region below the total
            S_REGION: begin
                lo_r    = (r_page > PW'(r_prot)) ? r_page : PW'(r_prot);
                hi_r    = ((r_page + PW'(r_count)) < PW'(r_total)) ?
                          (r_page + PW'(r_count)) : PW'(r_total);
                n_end   = r_page + PW'(r_count);
                n_lo    = lo_r;
                n_hi    = hi_r;
                n_mode  = WM_CLR;
                n_ret   = S_G_WALK;
                n_state = S_W_START;
            end

            S_G_WALK: begin
                if (r_page < r_end) begin
                    n_lo    = r_page;
                    n_hi    = r_page + PW'(1);
                    n_mode  = WM_CHK;
                    n_ret   = S_G_USED;
                    n_state = S_W_START;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_G_USED: begin
                if (!r_free) begin
                    n_page  = r_page + PW'(1);
                    n_state = S_G_WALK;
                end else begin
                    n_o     = OIW'(MAX_ORDER);
                    n_state = S_G_TRY;
                end
            end

            // largest aligned block that fits and is free
            S_G_TRY: begin
                if ((r_page & (bp - PW'(1))) == '0 && (r_page + bp) <= r_end) begin
                    n_lo    = r_page;
                    n_hi    = r_page + bp;
                    n_mode  = WM_CHK;
                    n_ret   = S_G_TRYC;
                    n_state = S_W_START;
                end else if (r_o == '0) begin
                    n_page  = r_page + PW'(1);
                    n_state = S_G_WALK;
                end else begin
                    n_o = r_o - OIW'(1);
                end
            end

            S_G_TRYC: begin
                if (r_free) begin
                    if (r_len[r_o] < cap_of(r_o)) begin
                        l_we       = 1'b1;
                        l_waddr    = base_of(r_o) + LAW'(r_len[r_o]);
                        l_wdata    = r_page;
                        n_len[r_o] = r_len[r_o] + LENW'(1);
                    end
                    n_page  = r_page + bp;
                    n_state = S_G_WALK;
                end else if (r_o == '0) begin
                    n_page  = r_page + PW'(1);
                    n_state = S_G_WALK;
                end else begin
                    n_o     = r_o - OIW'(1);
                    n_state = S_G_TRY;
                end
            end

            // bitmap walker: clip the range and set up the word span
            S_W_START: begin
                n_free = 1'b1;
                if (r_mode != WM_CHK && r_hi > PW'(PAGE_COUNT)) begin
                    hi_c = PW'(PAGE_COUNT);
                end
                if (r_mode == WM_CHK && r_hi > PW'(PAGE_COUNT)) begin
                    n_free  = 1'b0;
                    n_state = r_ret;
                end else if (r_lo >= hi_c) begin
                    n_state = r_ret;
                end else begin
                    hm1     = hi_c - PW'(1);
                    n_hi    = hi_c;
                    n_w     = r_lo[PW-1:WSH];
                    n_wl    = hm1[PW-1:WSH];
                    n_state = S_W_RD;
                end
            end

            S_W_RD: begin
                u_raddr = r_w[WAW-1:0];
                n_state = S_W_MOD;
            end

            // read-modify-write of one word, or a test of it
            S_W_MOD: begin
                lob  = (r_w == r_lo[PW-1:WSH]) ? r_lo[WSH-1:0] : '0;
                hib  = (r_w == r_wl) ? hm1[WSH-1:0] : WSH'(WORD_BITS - 1);
                mask = ({WORD_BITS{1'b1}} << lob) &
                       ({WORD_BITS{1'b1}} >> (WSH'(WORD_BITS - 1) - hib));
                if (r_mode == WM_CHK && (u_rdata & mask) != '0) begin
                    n_free  = 1'b0;
                    n_state = r_ret;
                end else begin
                    if (r_mode != WM_CHK) begin
                        u_we    = 1'b1;
                        u_wdata = (r_mode == WM_SET) ? (u_rdata | mask) : (u_rdata & ~mask);
                    end
                    if (r_w == r_wl) begin
                        n_state = r_ret;
                    end else begin
                        n_w     = r_w + WIW'(1);
                        n_state = S_W_RD;
                    end
                end
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_page   = r_res_page;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_w         <= '0;
            r_out_valid <= 1'b0;
            r_total     <= TOTAL_PAGES_RST;
            r_prot      <= PROTECTED_PAGES_RST;
            for (int k = 0; k < NUM_ORDERS; k++) begin
                r_len[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_out_valid <= n_out_valid;
            r_total     <= n_total;
            r_prot      <= n_prot;
            r_len       <= n_len;
        end
        r_ret        <= n_ret;
        r_mode       <= n_mode;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_wl         <= n_wl;
        r_free       <= n_free;
        r_count      <= n_count;
        r_page       <= n_page;
        r_end        <= n_end;
        r_q          <= n_q;
        r_blk        <= n_blk;
        r_o          <= n_o;
        r_want       <= n_want;
        r_i          <= n_i;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        r_out_page   <= n_out_page;
        r_out_status <= n_out_status;
    end

endmodule

// File: sim/buddy_page_allocator_checker.sv
// checker for the buddy page allocator: tracks bitmap and free lists, compares result beats
`timescale 1ns / 1ps

module buddy_page_allocator_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [bpa_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_first_page,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_count,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [bpa_pkg::PAGE_W-1:0]    i_block_page,
    input  logic [bpa_pkg::STATUS_W-1:0]  i_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    import bpa_pkg::*;

    localparam int ORDERS = MAX_ORDER_DEF + 1;
    localparam int PAGES  = PAGE_COUNT_DEF;

    typedef struct packed {
        logic [PAGE_W-1:0] block_page;
        t_status           status;
    } t_answer;

    // model state
    bit      page_used [PAGES];
    int      order_stacks [ORDERS][$];
    int      page_limit;
    int      protected_pages;
    t_answer answers_due [$];
    int      fails;

    initial begin
        foreach (page_used[i]) page_used[i] = 1'b1;
        fails = 0;
    end

    assign o_fail_count = fails;
    assign o_pending    = answers_due.size();

    function automatic bit is_used(int p);
        if (p >= PAGES) return 1'b1;
        return page_used[p];
    endfunction

    function automatic void set_used(int p, bit v);
        if (p < PAGES) page_used[p] = v;
    endfunction

    function automatic bit block_free(int p, int o);
        for (int i = 0; i < (1 << o); i++)
            if (is_used(p + i)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void mark_block(int p, int o, bit v);
        for (int i = 0; i < (1 << o); i++) set_used(p + i, v);
    endfunction

    // full list drops the push
    function automatic void push_block(int o, int p);
        if (order_stacks[o].size() >= (PAGES >> o)) return;
        order_stacks[o].push_back(p);
    endfunction

    // removes the newest matching entry
    function automatic bit unlist_block(int o, int p);
        for (int i = order_stacks[o].size(); i > 0; i--) begin
            if (order_stacks[o][i-1] == p) begin
                order_stacks[o].delete(i-1);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int order_of(int pages);
        int o;
        int sz;
        o  = 0;
        sz = 1;
        while (sz < pages && o < MAX_ORDER_DEF) begin
            sz = sz << 1;
            o++;
        end
        return o;
    endfunction

    function automatic t_answer serve_request(t_opcode op, int pg, int cnt);
        t_answer a;
        int      want;
        int      o;
        int      p;
        int      buddy;
        int      stop;
        bit      found;
        a.block_page = '0;
        a.status     = ST_OK;
        case (op)
            OP_ALLOC: begin
                if (cnt == 0 || cnt > (1 << MAX_ORDER_DEF)) begin
                    a.status = ST_BAD_COUNT;
                end else begin
                    want = order_of(cnt);
                    o = want;
                    while (o <= MAX_ORDER_DEF && order_stacks[o].size() == 0) o++;
                    if (o > MAX_ORDER_DEF) begin
                        a.status = ST_NO_MEMORY;
                    end else begin
                        p = order_stacks[o].pop_back();
                        mark_block(p, o, 1'b1);
                        // split, upper halves go back from high order down
                        while (o > want) begin
                            o--;
                            mark_block(p + (1 << o), o, 1'b0);
                            push_block(o, p + (1 << o));
                        end
                        a.block_page = PAGE_W'(p);
                    end
                end
            end
            OP_FREE: begin
                if (cnt == 0) begin
                    a.status = ST_BAD_COUNT;
                end else if (pg >= page_limit || pg < protected_pages) begin
                    a.status = ST_BAD_ADDR;
                end else begin
                    o = order_of(cnt);
                    p = pg;
                    mark_block(p, o, 1'b0);
                    // coalesce while the buddy is free and listed
                    while (o < MAX_ORDER_DEF) begin
                        buddy = p ^ (1 << o);
                        if (buddy >= page_limit || !block_free(buddy, o)) break;
                        if (!unlist_block(o, buddy)) break;
                        if (buddy < p) p = buddy;
                        o++;
                    end
                    push_block(o, p);
                end
            end
            OP_REGION: begin
                stop = pg + cnt;
                for (p = pg; p < stop; p++)
                    if (p >= protected_pages && p < page_limit) set_used(p, 1'b0);
                p = pg;
                // greedy walk, largest aligned free block first
                while (p < stop) begin
                    if (is_used(p)) begin
                        p++;
                    end else begin
                        found = 1'b0;
                        for (o = MAX_ORDER_DEF; o >= 0; o--) begin
                            if ((p & ((1 << o) - 1)) == 0 && p + (1 << o) <= stop
                                    && block_free(p, o)) begin
                                push_block(o, p);
                                p += (1 << o);
                                found = 1'b1;
                                break;
                            end
                        end
                        if (!found) p++;
                    end
                end
            end
            default: a.status = ST_BAD_COUNT;
        endcase
        return a;
    endfunction

    // watch all three channels
    always @(posedge i_clk) begin
        t_answer want_ans;
        if (!i_rst_n) begin
            page_limit      = int'(TOTAL_PAGES_RST);
            protected_pages = int'(PROTECTED_PAGES_RST);
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no request pending");
                    fails++;
                end else begin
                    want_ans = answers_due.pop_front();
                    if (i_block_page !== want_ans.block_page) begin
                        $error("block_page mismatch: expected %0d, actual %0d",
                               want_ans.block_page, i_block_page);
                        fails++;
                    end
                    if (i_status !== want_ans.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want_ans.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (t_cfg_index'(i_cfg_index) == CFG_TOTAL_PAGES)
                    page_limit = int'(i_cfg_data);
                else
                    protected_pages = int'(i_cfg_data);
            end
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(serve_request(t_opcode'(i_opcode),
                                                    int'(i_first_page), int'(i_page_count)));
        end
    end

endmodule

// File: sim/buddy_page_allocator_top_tb.sv
// testbench top for the buddy page allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps

module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OPCODE_W-1:0]  opcode;
    logic [PAGE_W-1:0]    first_page;
    logic [COUNT_W-1:0]   page_count;
    logic                 out_valid;
    logic                 out_stall;
    logic [PAGE_W-1:0]    block_page;
    logic [STATUS_W-1:0]  status;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_data;
    int                   fail_count;
    int                   pending;

    // receiver long hold-off request
    bit hold_off_req;
    // set by the receiver once the hold-off has run
    bit hold_off_done;
    // sender burst bookkeeping
    int burst_left;
    // live allocations seen on the result side, used to make good frees
    t_opcode sent_ops [$];
    int      sent_counts [$];
    int      live_pages [$];
    int      live_counts [$];

    buddy_page_allocator_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_first_page (first_page),
        .i_page_count (page_count),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_block_page (block_page),
        .o_status     (status),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    buddy_page_allocator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_first_page (first_page),
        .i_page_count (page_count),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_block_page (block_page),
        .i_status     (status),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #500_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int span;
        out_stall     = 1'b0;
        hold_off_done = 1'b0;
        mode = 0;
        span = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 200);
            end
            span--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // track allocated blocks from result beats
    always @(posedge i_clk) begin
        t_opcode op;
        int      cnt;
        if (in_valid && !in_stall) begin
            sent_ops.push_back(t_opcode'(opcode));
            sent_counts.push_back(int'(page_count));
        end
        if (out_valid && !out_stall && sent_ops.size() > 0) begin
            op  = sent_ops.pop_front();
            cnt = sent_counts.pop_front();
            if (op == OP_ALLOC && t_status'(status) == ST_OK) begin
                live_pages.push_back(int'(block_page));
                live_counts.push_back(cnt);
            end
        end
    end

    // one request beat, in bursts with random gaps
    task automatic send_request(t_opcode op, int pg, int cnt);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        first_page <= PAGE_W'(pg);
        page_count <= COUNT_W'(cnt);
        do @(posedge i_clk); while (!(in_valid && !in_stall));
        burst_left--;
        if (burst_left == 0) in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write, only once the block is idle
    task automatic write_reg(t_cfg_index idx, int value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COUNT_W'(value);
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // mostly frees of live blocks, allocs and small regions, some raw noise
    task automatic random_requests(int n);
        int pick;
        int k;
        int cnt;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024)
                                                  : (1 << $urandom_range(0, 4));
                send_request(OP_ALLOC, 0, cnt);
            end else if (pick < 75 && live_pages.size() > 0) begin
                k = $urandom_range(0, live_pages.size() - 1);
                send_request(OP_FREE, live_pages[k], live_counts[k]);
                live_pages.delete(k);
                live_counts.delete(k);
            end else if (pick < 85) begin
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 2048)
                                                   : $urandom_range(1, 64);
                send_request(OP_REGION, $urandom_range(0, 65535), cnt);
            end else if (pick < 95) begin
                send_request(($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_FREE,
                             $urandom_range(0, 65535), $urandom_range(0, 131071));
            end else begin
                send_request(OP_RSVD, $urandom_range(0, 65535), $urandom_range(0, 131071));
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_ALLOC;
        first_page   = '0;
        page_count   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TOTAL_PAGES;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        burst_left   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default registers
        send_request(OP_REGION, 0, 0);
        send_request(OP_REGION, 0, 8192);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 0, 1025);
        send_request(OP_ALLOC, 0, 65536);
        send_request(OP_ALLOC, 0, 1024);
        send_request(OP_ALLOC, 0, 1);
        send_request(OP_ALLOC, 0, 3);
        send_request(OP_RSVD, 65535, 131071);
        send_request(OP_FREE, 300, 0);
        send_request(OP_FREE, 0, 1);
        send_request(OP_FREE, 65535, 1);
        send_request(OP_FREE, 8194, 4);
        send_request(OP_FREE, 4096, 5000);
        send_request(OP_FREE, 4096, 1024);
        send_request(OP_REGION, 0, 8192);
        send_request(OP_REGION, 65500, 100);
        // drain the big blocks until memory runs out
        for (int i = 0; i < 30; i++) send_request(OP_ALLOC, 0, 1024);
        random_requests(250);
        wait_drained();
        random_requests(250);

        // small memory, nothing protected
        write_reg(CFG_TOTAL_PAGES, 4096);
        write_reg(CFG_PROTECTED_PAGES, 0);
        send_request(OP_FREE, 5000, 1);
        send_request(OP_REGION, 0, 4096);
        random_requests(400);

        // nothing exists, everything protected
        write_reg(CFG_TOTAL_PAGES, 0);
        write_reg(CFG_PROTECTED_PAGES, 65536);
        random_requests(100);

        // whole memory usable, lists overflow on the second add
        write_reg(CFG_TOTAL_PAGES, 65536);
        write_reg(CFG_PROTECTED_PAGES, 0);
        send_request(OP_REGION, 0, 65536);
        send_request(OP_REGION, 0, 65536);
        hold_off_req = 1'b1;
        random_requests(600);

        wait_drained();
        in_valid <= 1'b0;
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/buddy_page_allocator_top.sv
sim/buddy_page_allocator_checker.sv
sim/buddy_page_allocator_top_tb.sv
